// File: sv/assert_macros.svh
// Assertion macros used by the controller of the indexed list store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ILS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ILS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ILS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/ils_pkg.sv
// Package with the types and constants of the indexed list store.
package ils_pkg;

	localparam int DATA_W       = 32;
	localparam int IDX_W        = 7;
	localparam int LEN_W        = 7;
	localparam int OP_W         = 3;
	localparam int CAPACITY_DEF = 64;
	localparam int S_TDATA_W    = 48;
	localparam int M_TDATA_W    = 48;

	// Value returned by a read that misses.
	localparam logic [DATA_W-1:0] READ_MISS = '1;

	typedef enum logic [OP_W-1:0] {
		OP_READ     = 3'd0,
		OP_INS_HEAD = 3'd1,
		OP_INS_TAIL = 3'd2,
		OP_INS_AT   = 3'd3,
		OP_DELETE   = 3'd4
	} op_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

// File: sv/ils_cell.sv
// One storage cell of the list row: holds one entry and shifts with its neighbors.
module ils_cell #(
	parameter int POS = 0,
	parameter int CW  = 7
) (
	input  logic                      clk,
	input  ils_pkg::cell_cmd_t        cmd,
	input  logic [CW-1:0]             pos,
	input  logic [ils_pkg::DATA_W-1:0] left,
	input  logic [ils_pkg::DATA_W-1:0] right,
	output logic [ils_pkg::DATA_W-1:0] val,
	output logic [ils_pkg::DATA_W-1:0] rd_part
);
	import ils_pkg::*;

	localparam logic [CW-1:0] MY_POS = CW'(POS);

	logic [DATA_W-1:0] val_q;

	// Insert opens a gap at pos, delete closes the gap at pos.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_POS > pos) begin
				val_q <= left;
			end else if (MY_POS == pos) begin
				val_q <= cmd.value;
			end
		end else if (cmd.del) begin
			if (MY_POS >= pos) begin
				val_q <= right;
			end
		end
	end

	assign val = val_q;

	// The cell drives its entry onto the read bus only when addressed.
	assign rd_part = (MY_POS == pos) ? val_q : '0;

endmodule

// File: sv/ils_ctrl.sv
// Operation decoder, entry counter and result register of the list store.
`include "assert_macros.svh"
module ils_ctrl #(
	parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
	parameter int CW       = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ils_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [ils_pkg::DATA_W-1:0]  rd_bus,
	output ils_pkg::cell_cmd_t          cmd,
	output logic [CW-1:0]               pos
);
	import ils_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [OP_W-1:0]   in_op;
	logic [IDX_W-1:0]  in_index;
	logic [DATA_W-1:0] in_value;
	logic [CW-1:0]     idx_w;
	logic              accept;
	logic              room;
	logic              ins_ok;
	logic              del_ok;
	logic              hit;
	logic [DATA_W-1:0] rd_d;
	logic [CW-1:0]     count_q;
	logic [DATA_W-1:0] rd_q;
	logic              found_q;
	logic              done_q;
	logic [LEN_W-1:0]  len_q;
	logic              m_tvalid_q;

	// Unpack the input transfer.
	assign in_op    = s_tdata[OP_W-1:0];
	assign in_index = s_tdata[OP_W +: IDX_W];
	assign in_value = s_tdata[OP_W+IDX_W +: DATA_W];
	assign idx_w    = CW'(in_index);

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign room     = count_q < CAP_C;

	// Decode the operation into a cell command.
	always_comb begin
		ins_ok = 1'b0;
		del_ok = 1'b0;
		hit    = 1'b0;
		rd_d   = '0;
		pos    = idx_w;
		unique case (in_op)
			OP_READ: begin
				hit  = idx_w < count_q;
				rd_d = hit ? rd_bus : READ_MISS;
			end
			OP_INS_HEAD: begin
				ins_ok = room;
				pos    = '0;
			end
			OP_INS_TAIL: begin
				ins_ok = room;
				pos    = count_q;
			end
			OP_INS_AT: begin
				ins_ok = room && (idx_w <= count_q);
			end
			OP_DELETE: begin
				del_ok = idx_w < count_q;
			end
			default: begin
				ins_ok = 1'b0;
			end
		endcase
	end

	assign cmd.ins   = accept && ins_ok;
	assign cmd.del   = accept && del_ok;
	assign cmd.value = in_value;

	// Entry counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.del) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result register, loaded with each accepted transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q    <= rd_d;
			found_q <= hit;
			done_q  <= hit || ins_ok || del_ok;
			if (ins_ok) begin
				len_q <= LEN_W'(count_q + 1'b1);
			end else if (del_ok) begin
				len_q <= LEN_W'(count_q - 1'b1);
			end else begin
				len_q <= LEN_W'(count_q);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, len_q, done_q, found_q, rd_q};

	`ILS_ASSERT(a_count_bound, clk, arst_n, count_q <= CAP_C, "entry count above capacity")
	`ILS_ASSERT_NEVER(a_ins_del, clk, arst_n, cmd.ins && cmd.del, "insert and delete together")
	`ILS_ASSERT(a_ins_grow, clk, arst_n, cmd.ins |=> count_q == CW'($past(count_q) + 1'b1), "insert did not grow the list")
	`ILS_ASSERT(a_del_shrink, clk, arst_n, cmd.del |=> count_q == CW'($past(count_q) - 1'b1), "delete did not shrink the list")
	`ILS_ASSERT(a_result_valid, clk, arst_n, accept |=> m_tvalid_q, "accepted transfer gave no result")

endmodule

// File: sv/indexed_list_store_top.sv
// A result is registered and shown in the cycle after its input transfer is accepted.
// Throughput: one operation per cycle while results are taken; cells at and above pos update in that cycle.
// The output register frees s_tready whenever the held result is taken or absent.
// Reset clears the entry count and the output valid; entry cells keep their contents.
// Top level of the indexed list store: controller plus a row of shifting cells.
module indexed_list_store_top #(
	parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op [2:0], index [9:3], value [41:10], zero fill [47:42]
	input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_value [31:0], found [32], done_res [33], length [40:34], zero fill [47:41]
	output logic [ils_pkg::M_TDATA_W-1:0] m_tdata
);
	import ils_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int CW = (PW > IDX_W) ? PW : IDX_W;

	cell_cmd_t         cmd;
	logic [CW-1:0]     pos;
	logic [DATA_W-1:0] vals [CAPACITY];
	logic [DATA_W-1:0] rd_parts [CAPACITY];
	logic [DATA_W-1:0] rd_bus;

	ils_ctrl #(
		.CAPACITY(CAPACITY),
		.CW      (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.rd_bus  (rd_bus),
		.cmd     (cmd),
		.pos     (pos)
	);

	// Row of cells linked to their neighbors; the first takes cmd.value on the left, the last its own value on the right.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = cmd.value;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end
		ils_cell #(
			.POS(i),
			.CW (CW)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.pos    (pos),
			.left   (left_v),
			.right  (right_v),
			.val    (vals[i]),
			.rd_part(rd_parts[i])
		);
	end

	// Combine the gated cell outputs into the read bus.
	always_comb begin
		rd_bus = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_bus = rd_bus | rd_parts[k];
		end
	end

endmodule
